// ===== rtl/alm_pkg.sv =====
// Shared types, constants and functions of the level meter ballistics block.
package alm_pkg;

  // 20*log10(2) in Q16, scales a Q16 log2 into dB.
  localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;

  typedef enum logic [2:0] {
    CFG_FALL_STEP = 3'd0,
    CFG_HOLD      = 3'd1,
    CFG_AVG_COEF  = 3'd2,
    CFG_PEAK_INF  = 3'd3,
    CFG_AVG_INF   = 3'd4
  } cfg_idx_t;

  // Item after the log stage, before the per-channel update.
  typedef struct packed {
    logic [2:0]         channel;
    logic               zero;
    logic               neg;
    logic [39:0]        prod;
    logic signed [15:0] avg;
    logic [15:0]        ovf;
  } conv_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [15:0] peak_level;
    logic signed [15:0] peak_mark;
    logic signed [15:0] average_level;
    logic signed [15:0] average_mark;
    logic signed [15:0] maximum_peak;
    logic [31:0]        overflow_total;
  } res_t;

  typedef struct packed {
    logic signed [15:0] mark;
    logic [15:0]        timer;
  } mark_t;

  // Fractional log2 of (64 + k) / 64 in Q16 by repeated squaring.
  function automatic logic [15:0] frac_log2(input logic [5:0] k);
    logic [63:0] m;
    logic [15:0] r;
    m = 64'({1'b1, k}) << 24;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      r = {r[14:0], 1'b0};
      if (m >= 64'h0000_0000_8000_0000) begin
        r[0] = 1'b1;
        m    = m >> 1;
      end
    end
    return r;
  endfunction

  // Hold mark with hold timer, linear fall and infinite-hold mode.
  function automatic mark_t mark_update(input logic signed [15:0] level,
                                        input logic signed [15:0] mark,
                                        input logic [15:0]        timer,
                                        input logic               inf,
                                        input logic [15:0]        hold,
                                        input logic [15:0]        fall);
    mark_t              res;
    logic signed [15:0] cand;
    logic signed [17:0] fallen;
    logic [15:0]        tinc;
    cand   = (level > 16'sd0) ? 16'sd0 : level;
    fallen = $signed({{2{mark[15]}}, mark}) - $signed({2'b00, fall});
    tinc   = (timer == 16'hFFFF) ? timer : timer + 16'd1;
    res.mark  = mark;
    res.timer = timer;
    if (cand >= mark) begin
      res.mark = cand;
      if (!inf) begin
        res.timer = '0;
      end
    end else if (!inf) begin
      res.timer = tinc;
      if (tinc >= hold) begin
        if ($signed({{2{cand[15]}}, cand}) > fallen) begin
          res.mark = cand;
        end else begin
          res.mark = 16'(fallen);
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/alm_peak_log.sv =====
// Peak magnitude to Q16 log2 magnitude: leading-one position plus fraction table.
module alm_peak_log (
  input  logic [23:0] peak_i,
  output logic [20:0] mag_o,
  output logic        neg_o,
  output logic        zero_o
);

  logic [15:0] frac_tbl [64];
  logic [4:0]  pos;
  logic [5:0]  k;
  logic [15:0] frac;
  logic [29:0] shifted;

  for (genvar g = 0; g < 64; g++) begin : g_tbl
    assign frac_tbl[g] = alm_pkg::frac_log2(6'(g));
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < 24; i++) begin
      if (peak_i[i]) begin
        pos = 5'(i);
      end
    end
  end

  // The six bits below the leading one, zero-filled for small values.
  assign shifted = {peak_i, 6'b000000} >> pos;
  assign k       = shifted[5:0];
  assign frac    = frac_tbl[k];

  assign zero_o = (peak_i == 24'd0);
  assign neg_o  = (pos != 5'd23);
  assign mag_o  = neg_o ? ({5'd23 - pos, 16'h0000} - {5'b00000, frac})
                        : {5'b00000, frac};

endmodule

// ===== rtl/alm_chan_state.sv =====
// Per-channel meter state, configuration registers and the update logic.
module alm_chan_state #(
  parameter int                 CHANNELS  = 8,
  parameter logic signed [15:0] MIN_DB_Q8 = -16'sd23808
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               upd_i,
  input  alm_pkg::conv_t     conv_i,
  output alm_pkg::res_t      res_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0] fall_step_r;
  logic [15:0] hold_r;
  logic [15:0] avg_coef_r;
  logic        peak_inf_r;
  logic        avg_inf_r;

  logic signed [15:0] peak_bar_r  [CHANNELS];
  logic signed [15:0] peak_mark_r [CHANNELS];
  logic [15:0]        peak_tmr_r  [CHANNELS];
  logic signed [15:0] avg_bar_r   [CHANNELS];
  logic signed [15:0] avg_mark_r  [CHANNELS];
  logic [15:0]        avg_tmr_r   [CHANNELS];
  logic signed [15:0] record_r    [CHANNELS];
  logic [31:0]        ovf_sum_r   [CHANNELS];

  logic [IDX_W-1:0]   idx;
  logic               in_range;
  logic [40:0]        rnd_sum;
  logic [15:0]        rmag;
  logic signed [17:0] db_w;
  logic signed [17:0] min_w;
  logic signed [15:0] db;

  logic signed [15:0] bar;
  logic signed [17:0] bar_fall;
  logic signed [15:0] peak_bar_nxt;
  logic signed [15:0] record_nxt;
  alm_pkg::mark_t     peak_m;

  logic signed [16:0] diff;
  logic signed [33:0] avg_prod;
  logic signed [33:0] avg_adj;
  logic signed [17:0] avg_sum;
  logic signed [15:0] avg_bar_nxt;
  alm_pkg::mark_t     avg_m;

  logic [32:0]        ovf_wide;
  logic [31:0]        ovf_nxt;

  assign idx      = IDX_W'(conv_i.channel);
  assign in_range = (32'(conv_i.channel) < CHANNELS);

  // Round to nearest, halves away from zero, then floor at the meter minimum.
  assign rnd_sum = {1'b0, conv_i.prod} + 41'h00_0080_0000;
  assign rmag    = rnd_sum[39:24];
  assign db_w    = conv_i.neg ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
  assign min_w   = 18'(MIN_DB_Q8);
  assign db      = (conv_i.zero || (db_w < min_w)) ? MIN_DB_Q8 : 16'(db_w);

  always_comb begin
    bar      = peak_bar_r[idx];
    bar_fall = $signed({{2{bar[15]}}, bar}) - $signed({2'b00, fall_step_r});
    if (db >= bar) begin
      peak_bar_nxt = db;
    end else if ($signed({{2{db[15]}}, db}) > bar_fall) begin
      peak_bar_nxt = db;
    end else begin
      peak_bar_nxt = 16'(bar_fall);
    end
  end

  assign record_nxt = (db > record_r[idx]) ? db : record_r[idx];

  assign peak_m = alm_pkg::mark_update(db, peak_mark_r[idx], peak_tmr_r[idx],
                                       peak_inf_r, hold_r, fall_step_r);

  // Exponential smoothing; the product is truncated toward zero.
  assign diff     = $signed({avg_bar_r[idx][15], avg_bar_r[idx]})
                  - $signed({conv_i.avg[15], conv_i.avg});
  assign avg_prod = $signed({1'b0, avg_coef_r}) * diff;
  assign avg_adj  = avg_prod + (avg_prod[33] ? 34'sd65535 : 34'sd0);
  assign avg_sum  = $signed({{2{conv_i.avg[15]}}, conv_i.avg}) + $signed(avg_adj[33:16]);
  assign avg_bar_nxt = 16'(avg_sum);

  assign avg_m = alm_pkg::mark_update(avg_bar_nxt, avg_mark_r[idx], avg_tmr_r[idx],
                                      avg_inf_r, hold_r, fall_step_r);

  assign ovf_wide = {1'b0, ovf_sum_r[idx]} + 33'(conv_i.ovf);
  assign ovf_nxt  = ovf_wide[32] ? 32'hFFFF_FFFF : ovf_wide[31:0];

  always_comb begin
    res_o.channel = conv_i.channel;
    if (in_range) begin
      res_o.peak_level     = peak_bar_nxt;
      res_o.peak_mark      = peak_m.mark;
      res_o.average_level  = avg_bar_nxt;
      res_o.average_mark   = avg_m.mark;
      res_o.maximum_peak   = record_nxt;
      res_o.overflow_total = ovf_nxt;
    end else begin
      res_o.peak_level     = MIN_DB_Q8;
      res_o.peak_mark      = MIN_DB_Q8;
      res_o.average_level  = MIN_DB_Q8;
      res_o.average_mark   = MIN_DB_Q8;
      res_o.maximum_peak   = MIN_DB_Q8;
      res_o.overflow_total = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_step_r <= 16'd22;
      hold_r      <= 16'd1000;
      avg_coef_r  <= 16'd60693;
      peak_inf_r  <= 1'b0;
      avg_inf_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        alm_pkg::CFG_FALL_STEP: fall_step_r <= cfg_wdata;
        alm_pkg::CFG_HOLD:      hold_r      <= cfg_wdata;
        alm_pkg::CFG_AVG_COEF:  avg_coef_r  <= cfg_wdata;
        alm_pkg::CFG_PEAK_INF:  peak_inf_r  <= cfg_wdata[0];
        alm_pkg::CFG_AVG_INF:   avg_inf_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        peak_bar_r[c]  <= MIN_DB_Q8;
        peak_mark_r[c] <= MIN_DB_Q8;
        peak_tmr_r[c]  <= '0;
        avg_bar_r[c]   <= MIN_DB_Q8;
        avg_mark_r[c]  <= MIN_DB_Q8;
        avg_tmr_r[c]   <= '0;
        record_r[c]    <= MIN_DB_Q8;
        ovf_sum_r[c]   <= '0;
      end
    end else begin
      // A hold-mode write restarts that meter's hold timers on every channel not updated in that cycle.
      if (cfg_we && (cfg_index == alm_pkg::CFG_PEAK_INF)) begin
        for (int c = 0; c < CHANNELS; c++) begin
          peak_tmr_r[c] <= '0;
        end
      end
      if (cfg_we && (cfg_index == alm_pkg::CFG_AVG_INF)) begin
        for (int c = 0; c < CHANNELS; c++) begin
          avg_tmr_r[c] <= '0;
        end
      end
      if (upd_i && in_range) begin
        peak_bar_r[idx]  <= peak_bar_nxt;
        peak_mark_r[idx] <= peak_m.mark;
        peak_tmr_r[idx]  <= peak_m.timer;
        avg_bar_r[idx]   <= avg_bar_nxt;
        avg_mark_r[idx]  <= avg_m.mark;
        avg_tmr_r[idx]   <= avg_m.timer;
        record_r[idx]    <= record_nxt;
        ovf_sum_r[idx]   <= ovf_nxt;
      end
    end
  end

endmodule

// ===== rtl/audio_level_meter_ballistics.sv =====
// Top level of the per-channel audio level meter ballistics block.
// Each item passes the input register, the conversion register and the output register.
// Throughput: one item per cycle while out_tready does not stall the output; the channel
// state is updated in the same cycle as the item moves into the output register, so items
// for the same channel may follow back to back.
// Reset (rst_n low, synchronous) restores the valid flags, the configuration registers and all channel state at once.
module audio_level_meter_ballistics #(
  parameter int                 CHANNELS  = 8,
  parameter logic signed [15:0] MIN_DB_Q8 = -16'sd23808
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // channel[2:0], peak_linear[26:3], average_db[42:27], overflow_count[58:43]
  input  logic [63:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_channel[2:0], peak_level[18:3], peak_mark[34:19], average_level[50:35],
  // average_mark[66:51], maximum_peak[82:67], overflow_total[114:83]
  output logic [119:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  logic        s1_v_r;
  logic [2:0]  s1_ch_r;
  logic [23:0] s1_peak_r;
  logic [15:0] s1_avg_r;
  logic [15:0] s1_ovf_r;

  logic           s2_v_r;
  alm_pkg::conv_t s2_r;
  alm_pkg::conv_t s2_nxt;

  logic          out_v_r;
  alm_pkg::res_t out_r;
  alm_pkg::res_t res;

  logic        out_free;
  logic        s2_free;
  logic        s1_free;
  logic [20:0] mag;
  logic        neg;
  logic        zero;

  assign out_free  = !out_v_r || out_tready;
  assign s2_free   = !s2_v_r || out_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_tready = s1_free;

  alm_peak_log u_log (
    .peak_i (s1_peak_r),
    .mag_o  (mag),
    .neg_o  (neg),
    .zero_o (zero)
  );

  always_comb begin
    s2_nxt.channel = s1_ch_r;
    s2_nxt.zero    = zero;
    s2_nxt.neg     = neg;
    s2_nxt.prod    = 40'(mag) * 40'(alm_pkg::DB_PER_LOG2_Q16);
    s2_nxt.avg     = $signed(s1_avg_r);
    s2_nxt.ovf     = s1_ovf_r;
  end

  alm_chan_state #(
    .CHANNELS  (CHANNELS),
    .MIN_DB_Q8 (MIN_DB_Q8)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .upd_i     (s2_v_r && out_free),
    .conv_i    (s2_r),
    .res_o     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_free) begin
      s1_ch_r   <= in_tdata[2:0];
      s1_peak_r <= in_tdata[26:3];
      s1_avg_r  <= in_tdata[42:27];
      s1_ovf_r  <= in_tdata[58:43];
    end
    if (s1_v_r && s2_free) begin
      s2_r <= s2_nxt;
    end
    if (s2_v_r && out_free) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b00000, out_r.overflow_total, out_r.maximum_peak,
                       out_r.average_mark, out_r.average_level, out_r.peak_mark,
                       out_r.peak_level, out_r.channel};

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_v_r && !s2_v_r && !out_v_r))
    else $error("pipeline not empty after reset");

  a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_free) |=> out_v_r)
    else $error("item lost between update stage and output register");

  a_peak_mark_le0: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_r.peak_mark) <= 16'sd0))
    else $error("peak mark above 0 dB");

  a_avg_mark_le0: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_r.average_mark) <= 16'sd0))
    else $error("average mark above 0 dB");

endmodule
